[hw/rtl/wvir_pkg.sv]
// ----------------------------------------------------------------------------
// wvir_pkg: shared types and constants for the wavetable voice register block
// Beat layout widths, item kinds, bus port offsets and indirect register map.
// ----------------------------------------------------------------------------
`default_nettype none

package wvir_pkg;

  // beat layout
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // item kinds carried in tuser
  typedef enum logic [OPCODE_W-1:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_TIMER     = 3'd2,
    OP_VOICE_END = 3'd3,
    OP_TICK      = 3'd4
  } opcode_t;

  // bus port offsets
  typedef enum logic [1:0] {
    OFS_STATUS = 2'd0,
    OFS_SELECT = 2'd1,
    OFS_LO     = 2'd2,
    OFS_HI     = 2'd3
  } offset_t;

  // indirect register map
  localparam logic [7:0] REG_VOICE_CONF = 8'h00;
  localparam logic [7:0] REG_VOICE_INCR = 8'h06;
  localparam logic [7:0] REG_VOICE_ID   = 8'h0d;
  localparam logic [7:0] REG_VOICE_IRQ  = 8'h0f;
  localparam logic [7:0] REG_VOICE_CTRL = 8'h10;
  localparam logic [7:0] REG_TPRESET0   = 8'h40;
  localparam logic [7:0] REG_TPRESET1   = 8'h41;
  localparam logic [7:0] REG_TSCALE0    = 8'h42;
  localparam logic [7:0] REG_TSCALE1    = 8'h43;
  localparam logic [7:0] REG_IRQ_ENABLE = 8'h4a;
  localparam logic [7:0] REG_REV        = 8'h4b;
  localparam logic [7:0] REG_CHIP_CFG   = 8'h4c;
  localparam logic [7:0] REG_VOICE_SEL  = 8'h4f;

  // fixed values
  localparam logic [5:0]  TIMEOUT_RELOAD = 6'd40;
  localparam logic [15:0] VOICE_ID_VAL   = 16'h0100;
  localparam logic [15:0] REV_VAL        = 16'h0080;
  localparam logic [15:0] CHIP_CFG_VAL   = 16'h0001;
  localparam logic [15:0] NO_VOICE_VAL   = 16'hff00;
  localparam logic [2:0]  VOICE_IRQ_TAG  = 3'b010;   // 0x40 | voice, high byte
  localparam int unsigned CONF_LOOP_BIT  = 3;
  localparam logic [7:0]  STATUS_IRQ     = 8'h80;

endpackage

`default_nettype wire

[hw/rtl/wavetable_voice_irq_regs.sv]
// ----------------------------------------------------------------------------
// wavetable_voice_irq_regs: host register interface of a wavetable voice chip
// Indirect register file, per-voice state, timer pending bits and irq level.
// ----------------------------------------------------------------------------
// Each input beat is a bus read, a bus write, a timer expiry, a voice end or a
// frame tick; each one produces exactly one output beat with the read byte
// (zero unless a bus read) and the irq level after the beat took effect. All
// work for a beat is done between the input and the output register, so one
// beat is taken every cycle and its result appears in the next cycle; the
// only limit is the single output register, which stops input while a result
// waits unconsumed. The widest path is the 32-bit lowest finished-voice search
// feeding the finished-voice register read and the done-bit clear.
// Per-voice synthesis parameters other than config, increment and timeout are
// not held here.
`default_nettype none

module wavetable_voice_irq_regs #(
  parameter int unsigned NUM_VOICES    = 32,
  parameter int unsigned TICKED_VOICES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave side
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [1:0] offset, [9:2] data, [14:10] index, [15] zero
  input  wire logic [wvir_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [2:0] opcode
  input  wire logic [wvir_pkg::OPCODE_W-1:0]      s_axis_tuser,
  // master side
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] read_data, [8] irq, [15:9] zero
  output logic [wvir_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  import wvir_pkg::*;

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned NT = (TICKED_VOICES < NUM_VOICES) ? TICKED_VOICES : NUM_VOICES;

  // fields of the input beat
  opcode_t    opcode;
  offset_t    offset;
  logic [7:0] data;
  logic [4:0] index;

  assign opcode = opcode_t'(s_axis_tuser);
  assign offset = offset_t'(s_axis_tdata[1:0]);
  assign data   = s_axis_tdata[9:2];
  assign index  = s_axis_tdata[14:10];

  // state
  logic [7:0]            register_select;
  logic [4:0]            current_voice;
  logic [7:0]            irq_enable, irq_enable_next;
  logic [1:0]            irq_pending, irq_pending_next;
  logic [7:0]            timer_preset [2];
  logic [7:0]            timer_scale  [2];
  logic [7:0]            voice_conf    [NUM_VOICES];
  logic [15:0]           voice_incr    [NUM_VOICES];
  logic [5:0]            voice_timeout [NUM_VOICES];
  logic [NUM_VOICES-1:0] voice_on;
  logic [NUM_VOICES-1:0] voice_done, voice_done_next;

  // handshake
  logic accept;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // beat decode
  logic wr_lo, wr_hi, wr_data, rd_data;
  assign wr_lo   = accept && (opcode == OP_WRITE) && (offset == OFS_LO);
  assign wr_hi   = accept && (opcode == OP_WRITE) && (offset == OFS_HI);
  assign wr_data = wr_lo || wr_hi;
  assign rd_data = accept && (opcode == OP_READ) && ((offset == OFS_LO) || (offset == OFS_HI));

  // current voice and event voice addressing
  logic          cv_valid, ev_valid;
  logic [VW-1:0] cv_idx, ev_idx;
  assign cv_valid = {1'b0, current_voice} < 6'(NUM_VOICES);
  assign ev_valid = {1'b0, index} < 6'(NUM_VOICES);
  assign cv_idx   = current_voice[VW-1:0];
  assign ev_idx   = index[VW-1:0];

  // lowest finished voice
  logic          any_done;
  logic [VW-1:0] low_done;
  always_comb begin
    low_done = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (voice_done[v]) low_done = VW'(v);
    end
  end
  assign any_done = |voice_done;

  // voice end takes effect on an active voice unless looping with time left
  logic end_fire;
  always_comb begin
    end_fire = 1'b0;
    if (accept && (opcode == OP_VOICE_END) && ev_valid && voice_on[ev_idx]) begin
      end_fire = !voice_conf[ev_idx][CONF_LOOP_BIT] || (voice_timeout[ev_idx] == '0);
    end
  end

  // indirect register read value
  logic [15:0] reg_val;
  always_comb begin
    case (register_select)
      REG_VOICE_INCR: reg_val = cv_valid ? voice_incr[cv_idx] : '0;
      REG_VOICE_ID:   reg_val = VOICE_ID_VAL;
      REG_VOICE_IRQ:  reg_val = any_done ? {VOICE_IRQ_TAG, 5'(low_done), 8'h00} : NO_VOICE_VAL;
      REG_TPRESET0,
      REG_TPRESET1:   reg_val = {8'h00, timer_preset[register_select[0]]};
      REG_TSCALE1,
      REG_IRQ_ENABLE: reg_val = {14'd0, irq_pending};
      REG_REV:        reg_val = REV_VAL;
      REG_CHIP_CFG:   reg_val = CHIP_CFG_VAL;
      default:        reg_val = '0;
    endcase
  end

  // read byte for this beat, status uses the level before the beat
  logic       irq_now;
  logic [7:0] read_byte;
  assign irq_now = (|(irq_enable & {6'd0, irq_pending})) || any_done;
  always_comb begin
    read_byte = '0;
    if (opcode == OP_READ) begin
      case (offset)
        OFS_STATUS: begin
          if (irq_now) begin
            read_byte = STATUS_IRQ | {6'd0, any_done, |(irq_enable[1:0] & irq_pending)};
          end
        end
        OFS_SELECT: read_byte = register_select;
        OFS_LO:     read_byte = reg_val[7:0];
        OFS_HI:     read_byte = reg_val[15:8];
        default:    read_byte = '0;
      endcase
    end
  end

  // next values of the irq sources
  always_comb begin
    irq_enable_next  = irq_enable;
    irq_pending_next = irq_pending;
    voice_done_next  = voice_done;
    if (wr_lo && (register_select == REG_IRQ_ENABLE)) irq_enable_next = data;
    if (accept && (opcode == OP_TIMER) && (index < 5'd2)
        && (timer_preset[index[0]] != '0) && (timer_scale[index[0]] != '0)) begin
      irq_pending_next[index[0]] = 1'b1;
    end
    if (rd_data && ((register_select == REG_TPRESET0) || (register_select == REG_TPRESET1))) begin
      irq_pending_next[register_select[0]] = 1'b0;
    end
    if (rd_data && (register_select == REG_VOICE_IRQ) && any_done) begin
      voice_done_next[low_done] = 1'b0;
    end
    if (end_fire) voice_done_next[ev_idx] = 1'b1;
  end

  // control and global registers
  always_ff @(posedge clk) begin
    if (rst) begin
      register_select <= '0;
      current_voice   <= '0;
      irq_enable      <= '0;
      irq_pending     <= '0;
      voice_done      <= '0;
      timer_preset[0] <= '0;
      timer_preset[1] <= '0;
      timer_scale[0]  <= '0;
      timer_scale[1]  <= '0;
    end else begin
      irq_enable  <= irq_enable_next;
      irq_pending <= irq_pending_next;
      voice_done  <= voice_done_next;
      if (accept && (opcode == OP_WRITE) && (offset == OFS_SELECT)) register_select <= data;
      if (wr_lo) begin
        case (register_select)
          REG_TPRESET0,
          REG_TPRESET1:  timer_preset[register_select[0]] <= data;
          REG_TSCALE0,
          REG_TSCALE1:   timer_scale[register_select[0]] <= data;
          REG_VOICE_SEL: current_voice <= data[4:0];
          default: ;
        endcase
      end
    end
  end

  // per-voice registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_on <= '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        voice_conf[v]    <= '0;
        voice_incr[v]    <= '0;
        voice_timeout[v] <= '0;
      end
    end else begin
      // bus writes to the selected voice
      if (wr_data && cv_valid) begin
        voice_timeout[cv_idx] <= TIMEOUT_RELOAD;
        if (register_select == REG_VOICE_CONF && wr_hi) voice_conf[cv_idx] <= data;
        if (register_select == REG_VOICE_INCR) begin
          if (wr_hi) voice_incr[cv_idx][15:8] <= data;
          else       voice_incr[cv_idx][7:0]  <= data;
        end
        if (register_select == REG_VOICE_CTRL && wr_hi && data == '0) voice_on[cv_idx] <= 1'b1;
      end
      // voice end
      if (end_fire) voice_on[ev_idx] <= 1'b0;
      // frame tick counts down the ticked voices
      if (accept && (opcode == OP_TICK)) begin
        for (int v = 0; v < NT; v++) begin
          if (voice_on[v] && (voice_timeout[v] != '0)) voice_timeout[v] <= voice_timeout[v] - 6'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {7'd0,
                       (|(irq_enable_next & {6'd0, irq_pending_next})) || (|voice_done_next),
                       read_byte};
    end
  end

  // checks
  a_irq_matches_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tdata[8] == ((|(irq_enable & {6'd0, irq_pending})) || (|voice_done)))
    else $error("irq in result beat does not match updated state");

  a_read_only_on_bus_read: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode != OP_READ) |=> m_axis_tdata[7:0] == 8'h00)
    else $error("nonzero read byte for a beat that is not a bus read");

  a_pending_rises_on_timer: assert property (@(posedge clk) disable iff (rst)
    !(accept && (opcode == OP_TIMER)) |=> (irq_pending & ~$past(irq_pending)) == 2'b00)
    else $error("pending bit set without a timer expiry");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

`default_nettype wire
